// ----- hdl/chb_pkg.sv -----
// shared types and constants for the clamped bin histogram
// no dependencies; imported by every module of the block
`default_nettype none

package chb_pkg;

   localparam int unsigned NUM_BINS_DEF = 256;
   localparam int unsigned VAL_W        = 32;
   localparam int unsigned COUNT_W      = 48;
   localparam int unsigned IDX_IN_W     = 8;
   localparam int unsigned PROD_W       = VAL_W + IDX_IN_W;
   localparam int unsigned DIVD_W       = VAL_W + 1;

   typedef enum logic [1:0] {
      CSR_BASE       = 2'd0,
      CSR_CEIL       = 2'd1,
      CSR_WIDTH      = 2'd2,
      CSR_SHOW_EMPTY = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_READ = 1'b1
   } op_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic accept;
      logic clr_step;
      logic div_n_start;
      logic div_s_start;
      logic latch_n;
      logic mem_rd;
      logic mem_wb;
      logic out_load;
   } chb_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic clr_last;
      logic n_dirty;
      logic op_read;
      logic in_range;
      logic div_done;
      logic out_blocked;
   } chb_sts_type;

endpackage

`default_nettype wire

// ----- hdl/chb_div.sv -----
// restoring divider, one quotient bit per cycle, 33-bit dividend by 32-bit divisor
// depends on chb_pkg for widths
`default_nettype none

module chb_div import chb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIVD_W-1:0] dividend,
   input  wire logic [VAL_W-1:0]  divisor,
   output logic                   done,
   output logic [DIVD_W-1:0]      quotient
);

   localparam int unsigned STEP_W = $clog2(DIVD_W);

   logic [VAL_W-1:0]  rem_ff,  rem_in;
   logic [DIVD_W-1:0] quo_ff,  quo_in;
   logic [STEP_W-1:0] cnt_ff,  cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [VAL_W:0]    trial;
   logic [VAL_W:0]    diff;
   logic              fits;

   // shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, quo_ff[DIVD_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = STEP_W'(DIVD_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   ap_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");
   ap_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("divider did not go busy");
   ap_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) && !busy_ff)) else $error("divider done without a run");

endmodule

`default_nettype wire

// ----- hdl/chb_dpath.sv -----
// datapath: registers, bin count memory, divider, bin start multiplier, result register
// depends on chb_pkg and chb_div
`default_nettype none

module chb_dpath import chb_pkg::*; #(
   parameter int unsigned NUM_BINS = NUM_BINS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire csr_index_type       csr_index,
   input  wire logic [VAL_W-1:0]    csr_write_data,
   input  wire logic                req_operation,
   input  wire logic [VAL_W-1:0]    req_sample_value,
   input  wire logic [IDX_IN_W-1:0] req_bin_index,
   input  wire chb_cmd_type         cmd,
   output chb_sts_type              sts,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [COUNT_W-1:0]       rsp_bin_start,
   output logic [COUNT_W-1:0]       rsp_bin_count,
   output logic                     rsp_listed,
   output logic                     rsp_bin_in_use
);

   localparam int unsigned IDX_W = $clog2(NUM_BINS);
   localparam int unsigned CNT_W = $clog2(NUM_BINS + 1);

   // configuration
   logic [VAL_W-1:0] base_ff, ceil_ff, width_ff;
   logic             show_ff;
   logic [VAL_W-1:0] weff;

   // latched word
   op_type                op_ff;
   logic [VAL_W-1:0]      val_ff;
   logic [IDX_IN_W-1:0]   idx_ff;

   // bins in use
   logic [CNT_W-1:0]      n_ff, n_in, n_m1;
   logic                  n_dirty_ff, n_dirty_in;

   // divider
   logic [DIVD_W-1:0]     top_sum, n_dividend, s_dividend, div_dividend, quo;
   logic                  div_done;

   // memory access
   logic [COUNT_W-1:0]    mem [NUM_BINS];
   logic [COUNT_W-1:0]    rd_data_ff;
   logic [IDX_W-1:0]      addr_ff, rd_addr, sample_bin, idx_addr;
   logic [IDX_W-1:0]      clr_addr_ff, clr_addr_in;
   logic [31:0]           idx_ext;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic [COUNT_W-1:0]    mem_wdata, inc_count;
   logic [PROD_W-1:0]     prod_ff;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]    start_ff, count_ff, count_sel;
   logic                  listed_ff, in_use_ff;

   assign weff = (width_ff == '0) ? VAL_W'(1) : width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= VAL_W'(1);
         ceil_ff  <= VAL_W'(256);
         width_ff <= VAL_W'(1);
         show_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BASE:       base_ff  <= csr_write_data;
            CSR_CEIL:       ceil_ff  <= csr_write_data;
            CSR_WIDTH:      width_ff <= csr_write_data;
            CSR_SHOW_EMPTY: show_ff  <= csr_write_data[0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= op_type'(req_operation);
         val_ff <= req_sample_value;
         idx_ff <= req_bin_index;
      end
   end

   // bins in use = (ceil + width - base) / width, then held to 1..NUM_BINS
   assign top_sum    = {1'b0, ceil_ff} + {1'b0, weff};
   assign n_dividend = (top_sum >= {1'b0, base_ff}) ? top_sum - {1'b0, base_ff} : '0;
   assign s_dividend = {1'b0, val_ff - base_ff};
   assign div_dividend = cmd.div_n_start ? n_dividend : s_dividend;

   chb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_n_start | cmd.div_s_start),
      .dividend (div_dividend),
      .divisor  (weff),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      if (quo == '0) begin
         n_in = CNT_W'(1);
      end else if (quo > DIVD_W'(NUM_BINS)) begin
         n_in = CNT_W'(NUM_BINS);
      end else begin
         n_in = quo[CNT_W-1:0];
      end
   end

   // any register write may change the bin layout
   always_comb begin
      n_dirty_in = n_dirty_ff;
      if (cmd.latch_n) begin
         n_dirty_in = 1'b0;
      end
      if (csr_write_enable) begin
         n_dirty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff       <= CNT_W'(1);
         n_dirty_ff <= 1'b1;
      end else begin
         if (cmd.latch_n) begin
            n_ff <= n_in;
         end
         n_dirty_ff <= n_dirty_in;
      end
   end

   assign n_m1 = n_ff - 1'b1;

   // target bin of an add word
   always_comb begin
      if (val_ff < base_ff) begin
         sample_bin = '0;
      end else if (val_ff > ceil_ff) begin
         sample_bin = n_m1[IDX_W-1:0];
      end else if (quo >= DIVD_W'(n_ff)) begin
         sample_bin = n_m1[IDX_W-1:0];
      end else begin
         sample_bin = quo[IDX_W-1:0];
      end
   end

   assign idx_ext  = 32'(idx_ff);
   assign idx_addr = idx_ext[IDX_W-1:0];
   assign rd_addr  = (op_ff == OP_READ) ? idx_addr : sample_bin;

   // clearing pass after reset, one entry a cycle
   assign clr_addr_in = cmd.clr_step ? clr_addr_ff + 1'b1 : clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
      end
   end

   // saturating increment
   assign inc_count = (&rd_data_ff) ? rd_data_ff : rd_data_ff + COUNT_W'(1);

   assign mem_we    = cmd.clr_step | cmd.mem_wb;
   assign mem_waddr = cmd.clr_step ? clr_addr_ff : addr_ff;
   assign mem_wdata = cmd.clr_step ? '0 : inc_count;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[rd_addr];
         addr_ff    <= rd_addr;
         prod_ff    <= PROD_W'(idx_ff) * PROD_W'(weff);
      end
   end

   // read past the store gives zero
   assign count_sel = (idx_ext < 32'(NUM_BINS)) ? rd_data_ff : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.out_load) begin
         start_ff  <= COUNT_W'(base_ff) + COUNT_W'(prod_ff);
         count_ff  <= count_sel;
         listed_ff <= (count_sel != '0) | show_ff;
         in_use_ff <= idx_ext < 32'(n_ff);
      end
   end

   assign sts.clr_last    = clr_addr_ff == IDX_W'(NUM_BINS - 1);
   assign sts.n_dirty     = n_dirty_ff;
   assign sts.op_read     = op_ff == OP_READ;
   assign sts.in_range    = (val_ff >= base_ff) && (val_ff <= ceil_ff);
   assign sts.div_done    = div_done;
   assign sts.out_blocked = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bin_start  = start_ff;
   assign rsp_bin_count  = count_ff;
   assign rsp_listed     = listed_ff;
   assign rsp_bin_in_use = in_use_ff;

   ap_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && !rsp_ready)) else $error("result word overwritten");
   ap_n_range: assert property (@(posedge clock) disable iff (reset)
      !n_dirty_ff |-> (n_ff != '0 && n_ff <= CNT_W'(NUM_BINS)))
      else $error("bins in use out of range");
   ap_single_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clr_step && cmd.mem_wb)) else $error("clear and update collide");

endmodule

`default_nettype wire

// ----- hdl/chb_ctrl.sv -----
// controller state machine: clearing pass, bin layout refresh, add and read sequencing
// depends on chb_pkg
`default_nettype none

module chb_ctrl import chb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire chb_sts_type sts,
   output chb_cmd_type      cmd
);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_PREP  = 7'b0000100,
      S_NDIV  = 7'b0001000,
      S_SDIV  = 7'b0010000,
      S_RD    = 7'b0100000,
      S_WB    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_PREP;
            end
         end
         S_PREP: begin
            // refresh bins in use first if a register changed
            if (sts.n_dirty) begin
               cmd.div_n_start = 1'b1;
               state_in        = S_NDIV;
            end else if (sts.op_read || !sts.in_range) begin
               state_in = S_RD;
            end else begin
               cmd.div_s_start = 1'b1;
               state_in        = S_SDIV;
            end
         end
         S_NDIV: begin
            if (sts.div_done) begin
               cmd.latch_n = 1'b1;
               state_in    = S_PREP;
            end
         end
         S_SDIV: begin
            if (sts.div_done) begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_WB;
         end
         S_WB: begin
            if (!sts.op_read) begin
               cmd.mem_wb = 1'b1;
               state_in   = S_IDLE;
            end else if (!sts.out_blocked) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   ap_fresh_layout: assert property (@(posedge clock) disable iff (reset)
      cmd.div_s_start |-> !sts.n_dirty) else $error("sample binned with stale layout");
   ap_wb_after_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_wb |-> $past(cmd.mem_rd)) else $error("update without fresh read");

endmodule

`default_nettype wire

// ----- hdl/clamped_bin_histogram.sv -----
// Clamped bin histogram, top level.
// Input channel req_*: one word is either an add (req_operation 0, bins
// req_sample_value) or a read (req_operation 1, reports bin req_bin_index).
// Result channel rsp_*: one word per read, none per add. rsp_bin_start is
// base + index * width, rsp_bin_count the saturating count, rsp_listed and
// rsp_bin_in_use the two flags.
// csr_*: register writes (base, ceil, width, show_empty), to be issued only while idle.
// Sequencing: a read, or an add outside base..ceil, skips the divider; an
// add inside it runs the shift-subtract divider to find its bin. The
// first word after any register write also runs the same divider beforehand
// to recompute the number of bins in use.
// Reset: a clearing pass writes zero to every bin, and no word is taken
// until it ends; registers return to their reset values.
// Stall: the result sits in an output register; a stalled receiver holds only
// the next read at its final step; adds ahead of it keep flowing.
// depends on chb_pkg, chb_ctrl, chb_dpath
`default_nettype none

module clamped_bin_histogram import chb_pkg::*; #(
   parameter int unsigned NUM_BINS = NUM_BINS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [1:0]          csr_index,
   input  wire logic [VAL_W-1:0]    csr_write_data,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_operation,
   input  wire logic [VAL_W-1:0]    req_sample_value,
   input  wire logic [IDX_IN_W-1:0] req_bin_index,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [COUNT_W-1:0]       rsp_bin_start,
   output logic [COUNT_W-1:0]       rsp_bin_count,
   output logic                     rsp_listed,
   output logic                     rsp_bin_in_use
);

   chb_cmd_type cmd;
   chb_sts_type sts;

   chb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   chb_dpath #(
      .NUM_BINS (NUM_BINS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index_type'(csr_index)),
      .csr_write_data   (csr_write_data),
      .req_operation    (req_operation),
      .req_sample_value (req_sample_value),
      .req_bin_index    (req_bin_index),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bin_start    (rsp_bin_start),
      .rsp_bin_count    (rsp_bin_count),
      .rsp_listed       (rsp_listed),
      .rsp_bin_in_use   (rsp_bin_in_use)
   );

endmodule

`default_nettype wire
